>>> design/sle_pkg.sv
// Package for the length-negotiated SPI exchange controller
// Holds sizes, codes and the structs passed between front, queue and back.
// No dependencies.
`default_nettype none

package sle_pkg;

   // transmit store
   localparam int STORE_DEPTH = 256;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // configuration port
   localparam int CSR_IW = 1;
   localparam int CSR_DW = 16;
   localparam logic [CSR_IW-1:0] CSR_DUMMY_BYTE = 1'd0;
   localparam logic [CSR_IW-1:0] CSR_WAIT_LIMIT = 1'd1;

   localparam logic [7:0]  DUMMY_RESET      = 8'hFF;
   localparam logic [15:0] WAIT_LIMIT_RESET = 16'd2000;
   localparam logic [15:0] WAIT_MAX         = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_XFER  = 2'd2,
      OP_TICK  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_LENGTH = 2'd1,
      PHASE_DATA   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_REJECT  = 2'd1,
      STATUS_TIMEOUT = 2'd2
   } status_type;

   // classified event: arg is tx_byte, local_length or rx_byte by op
   typedef struct packed {
      op_type     op;
      logic [7:0] index;
      logic [7:0] arg;
   } entry_type;

   // result waiting at the output, before the store byte is merged in
   typedef struct packed {
      logic       send_valid;
      logic       send_from_store;
      logic [7:0] send_byte;
      logic       recv_valid;
      logic [7:0] recv_index;
      logic [7:0] recv_byte;
      logic       done;
      status_type status;
      logic       busy;
   } result_type;

endpackage

`default_nettype wire

>>> design/sle_channels.sv
// Request and response channel interfaces of the SPI exchange controller
// Valid/ready handshake with the event or result fields as payload.
// Depends on nothing.
`default_nettype none

interface sle_req_if ();
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] tx_index;
   logic [7:0] tx_byte;
   logic [7:0] local_length;
   logic [7:0] rx_byte;

   modport source (output valid, action, tx_index, tx_byte, local_length, rx_byte,
                   input ready);
   modport sink (input valid, action, tx_index, tx_byte, local_length, rx_byte,
                 output ready);
endinterface

interface sle_rsp_if ();
   logic       valid;
   logic       ready;
   logic       send_valid;
   logic [7:0] send_byte;
   logic       recv_valid;
   logic [7:0] recv_index;
   logic [7:0] recv_byte;
   logic       done_res;
   logic [1:0] status;
   logic       busy_res;

   modport source (output valid, send_valid, send_byte, recv_valid, recv_index,
                   recv_byte, done_res, status, busy_res,
                   input ready);
   modport sink (input valid, send_valid, send_byte, recv_valid, recv_index,
                 recv_byte, done_res, status, busy_res,
                 output ready);
endinterface

`default_nettype wire

>>> design/spi_length_negotiated_exchange_core.sv
// Length-negotiated SPI exchange controller, top level
// rsp valid rises once the event has passed through the queue and then the output register.
// Throughput: one event per cycle while the output register is empty or being taken, set by the exchange state update.
// Reset: synchronous; clears the queue, the exchange state and the store valid
// bits at once, so the store reads as zero with no clearing pass.
// Depends on sle_pkg, sle_channels, sle_front, sle_queue and sle_back.
`default_nettype none

module spi_length_negotiated_exchange_core
   import sle_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   sle_req_if.sink                req_ch,
   sle_rsp_if.source              rsp_ch,
   input  wire logic              csr_write,
   input  wire logic [CSR_IW-1:0] csr_index,
   input  wire logic [CSR_DW-1:0] csr_data
);

   logic      push;
   entry_type push_entry;
   logic      queue_full;
   logic      pop;
   entry_type pop_entry;
   logic      not_empty;

   // classify incoming events
   sle_front u_front (
      .req        (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // decouple front and back
   sle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .not_empty  (not_empty)
   );

   // run the exchange
   sle_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (not_empty),
      .entry       (pop_entry),
      .pop         (pop),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp         (rsp_ch)
   );

endmodule

`default_nettype wire

>>> design/sle_ram.sv
// Generic single-write, single-read RAM with registered read data
// Used for the transmit store. No dependencies.
`default_nettype none

module sle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/sle_front.sv
// Front end: takes request transfers and classifies them into queue entries
// Depends on sle_pkg and sle_channels.
`default_nettype none

module sle_front
   import sle_pkg::*;
(
   sle_req_if.sink         req,
   input  wire logic       queue_full,
   output logic            push,
   output entry_type       push_entry
);

   // accept whenever the queue has room
   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   // keep only the operand that the action uses
   always_comb begin
      push_entry.op    = op_type'(req.action);
      push_entry.index = req.tx_index;
      case (op_type'(req.action))
         OP_LOAD:  push_entry.arg = req.tx_byte;
         OP_START: push_entry.arg = req.local_length;
         OP_XFER:  push_entry.arg = req.rx_byte;
         default:  push_entry.arg = 8'd0;
      endcase
   end

endmodule

`default_nettype wire

>>> design/sle_queue.sv
// Short FIFO of classified events between front and back
// Depends on sle_pkg.
`default_nettype none

module sle_queue
   import sle_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output logic           full,
   input  wire logic      pop,
   output entry_type      pop_entry,
   output logic           not_empty
);

   entry_type               slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff;
   logic [QUEUE_AW-1:0]     wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff;
   logic [QUEUE_AW-1:0]     rd_ptr_in;
   logic [QUEUE_CW-1:0]     count_ff;
   logic [QUEUE_CW-1:0]     count_in;
   logic                    do_pop;

   assign full      = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_pop    = pop && not_empty;
   assign pop_entry = slots_ff[rd_ptr_ff];

   // pointer and count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

>>> design/sle_back.sv
// Back end: exchange state machine, transmit store and output register
// Depends on sle_pkg, sle_channels and sle_ram.
`default_nettype none

module sle_back
   import sle_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              entry_valid,
   input  wire entry_type         entry,
   output logic                   pop,
   input  wire logic              csr_write,
   input  wire logic [CSR_IW-1:0] csr_index,
   input  wire logic [CSR_DW-1:0] csr_data,
   sle_rsp_if.source              rsp
);

   phase_type            phase_ff, phase_in;
   logic [7:0]           byte_count_ff, byte_count_in;
   logic [7:0]           exch_length_ff, exch_length_in;
   logic [7:0]           own_length_ff, own_length_in;
   logic [15:0]          wait_count_ff, wait_count_in;
   logic [7:0]           dummy_byte_ff;
   logic [15:0]          wait_limit_ff;
   logic [STORE_DEPTH-1:0] store_valid_ff;
   logic                 hit_ff, hit_in;
   logic                 res_valid_ff;
   result_type           res_ff, res_in;

   logic                 fire;
   logic                 busy;
   logic                 in_length;
   logic                 in_data;
   logic [7:0]           length_max;
   logic [7:0]           eff_length;
   logic [7:0]           eff_count;
   logic                 more;
   logic [15:0]          wait_inc;
   logic                 tick_live;
   logic                 timeout;
   logic                 load_hit;
   logic [STORE_AW-1:0]  rd_addr;
   logic [7:0]           rd_data;

   // one event per cycle while the output register can take its result
   assign fire = entry_valid && (!res_valid_ff || rsp.ready);
   assign pop  = fire;

   // shared decisions
   assign in_length  = (phase_ff == PHASE_LENGTH);
   assign in_data    = (phase_ff == PHASE_DATA);
   assign busy       = in_length || in_data;
   assign length_max = (entry.arg > own_length_ff) ? entry.arg : own_length_ff;
   assign eff_length = in_length ? length_max : exch_length_ff;
   assign eff_count  = in_length ? 8'd0 : byte_count_ff;
   assign more       = (eff_count < eff_length);
   assign wait_inc   = (wait_count_ff == WAIT_MAX) ? wait_count_ff : wait_count_ff + 16'd1;
   assign tick_live  = busy && (wait_limit_ff != 16'd0);
   assign timeout    = (wait_inc >= wait_limit_ff);

   // next state
   always_comb begin
      phase_in       = phase_ff;
      byte_count_in  = byte_count_ff;
      exch_length_in = exch_length_ff;
      own_length_in  = own_length_ff;
      wait_count_in  = wait_count_ff;
      case (entry.op)
         OP_START: begin
            if (!busy) begin
               own_length_in  = entry.arg;
               byte_count_in  = 8'd0;
               exch_length_in = 8'd0;
               wait_count_in  = 16'd0;
               phase_in       = PHASE_LENGTH;
            end
         end
         OP_XFER: begin
            if (busy) begin
               exch_length_in = eff_length;
               wait_count_in  = 16'd0;
               if (more) begin
                  byte_count_in = eff_count + 8'd1;
                  phase_in      = PHASE_DATA;
               end else begin
                  byte_count_in = 8'd0;
                  phase_in      = PHASE_IDLE;
               end
            end
         end
         OP_TICK: begin
            if (tick_live) begin
               if (timeout) begin
                  phase_in      = PHASE_IDLE;
                  byte_count_in = 8'd0;
                  wait_count_in = 16'd0;
               end else begin
                  wait_count_in = wait_inc;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // result fields
   always_comb begin
      res_in        = '0;
      res_in.status = STATUS_OK;
      case (entry.op)
         OP_START: begin
            if (busy) begin
               res_in.status = STATUS_REJECT;
            end else begin
               res_in.send_valid = 1'b1;
               res_in.send_byte  = entry.arg;
            end
         end
         OP_XFER: begin
            if (in_data) begin
               res_in.recv_valid = 1'b1;
               res_in.recv_index = byte_count_ff - 8'd1;
               res_in.recv_byte  = entry.arg;
            end
            if (busy) begin
               if (more) begin
                  res_in.send_valid      = 1'b1;
                  res_in.send_from_store = 1'b1;
               end else begin
                  res_in.done = 1'b1;
               end
            end
         end
         OP_TICK: begin
            if (tick_live && timeout) begin
               res_in.status = STATUS_TIMEOUT;
            end
         end
         default: begin
         end
      endcase
      res_in.busy = (phase_in != PHASE_IDLE);
   end

   // exchange state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PHASE_IDLE;
         byte_count_ff  <= 8'd0;
         exch_length_ff <= 8'd0;
         own_length_ff  <= 8'd0;
         wait_count_ff  <= 16'd0;
      end else if (fire) begin
         phase_ff       <= phase_in;
         byte_count_ff  <= byte_count_in;
         exch_length_ff <= exch_length_in;
         own_length_ff  <= own_length_in;
         wait_count_ff  <= wait_count_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dummy_byte_ff <= DUMMY_RESET;
         wait_limit_ff <= WAIT_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DUMMY_BYTE: dummy_byte_ff <= csr_data[7:0];
            CSR_WAIT_LIMIT: wait_limit_ff <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // transmit store: entries never loaded read as zero
   assign load_hit = fire && (entry.op == OP_LOAD)
                     && ({1'b0, entry.index} < 9'(STORE_DEPTH));
   assign rd_addr  = eff_count[STORE_AW-1:0];
   assign hit_in   = ({1'b0, eff_count} < 9'(STORE_DEPTH)) && store_valid_ff[rd_addr];

   always_ff @(posedge clock) begin
      if (reset) begin
         store_valid_ff <= '0;
      end else if (load_hit) begin
         store_valid_ff[entry.index[STORE_AW-1:0]] <= 1'b1;
      end
   end

   sle_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (load_hit),
      .wr_addr (entry.index[STORE_AW-1:0]),
      .wr_data (entry.arg),
      .rd_en   (fire),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (fire) begin
         res_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         res_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         res_ff <= res_in;
         hit_ff <= hit_in;
      end
   end

   // merge the store byte, dummy in place of zero
   assign rsp.valid      = res_valid_ff;
   assign rsp.send_valid = res_ff.send_valid;
   assign rsp.send_byte  = !res_ff.send_from_store ? res_ff.send_byte :
                           (hit_ff && (rd_data != 8'd0)) ? rd_data : dummy_byte_ff;
   assign rsp.recv_valid = res_ff.recv_valid;
   assign rsp.recv_index = res_ff.recv_index;
   assign rsp.recv_byte  = res_ff.recv_byte;
   assign rsp.done_res   = res_ff.done;
   assign rsp.status     = res_ff.status;
   assign rsp.busy_res   = res_ff.busy;

endmodule

`default_nettype wire
